>>> rtl/tbuv_pkg.sv
// Shared types and constants of the barycentric texture coordinate unit.
`default_nettype none

package tbuv_pkg;

    // Result coordinates are signed Q3.14 in an 18-bit field
    localparam int OUT_W = 18;
    // Quotient magnitude bits kept by the divider (one above the field)
    localparam int QW = OUT_W + 1;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_C = 2'd2;

    // Dot product slots
    localparam int NUM_DOTS = 5;
    localparam int DOT_00 = 0;  // ab.ab
    localparam int DOT_01 = 1;  // ab.ac
    localparam int DOT_11 = 2;  // ac.ac
    localparam int DOT_20 = 3;  // ap.ab
    localparam int DOT_21 = 4;  // ap.ac

    // Sideband that travels with an item through the divider
    typedef struct packed {
        logic       degen;  // denominator is zero
        logic [1:0] neg;    // quotient sign, lane 0 = u, lane 1 = v
    } t_side;

endpackage

`default_nettype wire

>>> rtl/tbuv_if.sv
// Channel interfaces: query points, texture results and register writes.
`default_nettype none

interface tbuv_point_if #(
    parameter int CW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface tbuv_uv_if import tbuv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] tex_u;
    logic signed [OUT_W-1:0] tex_v;
    logic                    degenerate;
    logic                    clipped;

    modport source (output valid, tex_u, tex_v, degenerate, clipped, input ready);
    modport sink   (input valid, tex_u, tex_v, degenerate, clipped, output ready);
endinterface

interface tbuv_cfg_if import tbuv_pkg::*; #(
    parameter int CW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [3*CW-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/tbuv_front.sv
// Edge vectors and the five dot products, three pipeline stages.
`default_nettype none

module tbuv_front import tbuv_pkg::*; #(
    parameter int CW = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [CW-1:0]   i_px,
    input  wire logic signed [CW-1:0]   i_py,
    input  wire logic signed [CW-1:0]   i_pz,
    input  wire logic [3*CW-1:0]        i_va,
    input  wire logic [3*CW-1:0]        i_vb,
    input  wire logic [3*CW-1:0]        i_vc,
    output logic                        o_valid,
    output logic signed [2*CW+3:0]      o_dot [NUM_DOTS]
);
    localparam int DIFW = CW + 1;
    localparam int PRODW = 2 * DIFW;
    localparam int DOTW = PRODW + 2;

    logic signed [CW-1:0]    w_a [3];
    logic signed [CW-1:0]    w_b [3];
    logic signed [CW-1:0]    w_c [3];
    logic signed [CW-1:0]    w_p [3];
    logic signed [DIFW-1:0]  r_ab [3];
    logic signed [DIFW-1:0]  r_ac [3];
    logic signed [DIFW-1:0]  r_ap [3];
    logic signed [PRODW-1:0] r_prod [NUM_DOTS][3];
    logic signed [DOTW-1:0]  r_dot [NUM_DOTS];
    logic [2:0]              r_v;

    // unpack the vertex fields, x lowest
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[k] = signed'(i_va[k*CW +: CW]);
            w_b[k] = signed'(i_vb[k*CW +: CW]);
            w_c[k] = signed'(i_vc[k*CW +: CW]);
        end
        w_p[0] = i_px;
        w_p[1] = i_py;
        w_p[2] = i_pz;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                // stage 1: differences against vertex a
                r_ab[k] <= DIFW'(w_b[k]) - DIFW'(w_a[k]);
                r_ac[k] <= DIFW'(w_c[k]) - DIFW'(w_a[k]);
                r_ap[k] <= DIFW'(w_p[k]) - DIFW'(w_a[k]);
                // stage 2: per-axis products
                r_prod[DOT_00][k] <= r_ab[k] * r_ab[k];
                r_prod[DOT_01][k] <= r_ab[k] * r_ac[k];
                r_prod[DOT_11][k] <= r_ac[k] * r_ac[k];
                r_prod[DOT_20][k] <= r_ap[k] * r_ab[k];
                r_prod[DOT_21][k] <= r_ap[k] * r_ac[k];
            end
            // stage 3: sums over the axes
            for (int j = 0; j < NUM_DOTS; j++) begin
                r_dot[j] <= DOTW'(r_prod[j][0]) + DOTW'(r_prod[j][1])
                          + DOTW'(r_prod[j][2]);
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_dot   = r_dot;

endmodule

`default_nettype wire

>>> rtl/tbuv_cramer.sv
// Cramer's rule numerators and denominator, with signs and magnitudes.
`default_nettype none

module tbuv_cramer import tbuv_pkg::*; #(
    parameter int CW = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [2*CW+3:0] i_dot [NUM_DOTS],
    output logic                        o_valid,
    output logic [4*CW+8:0]             o_den,
    output logic [4*CW+9:0]             o_mag [2],
    output t_side                       o_side
);
    localparam int DOTW = 2 * CW + 4;
    localparam int MULW = 2 * DOTW;
    localparam int DENW = MULW + 1;
    localparam int NUMW = MULW + 2;

    logic signed [MULW-1:0] r_m [6];
    logic signed [DENW-1:0] r_den5;
    logic signed [DENW-1:0] r_nx;
    logic signed [DENW-1:0] r_ny;
    logic signed [DENW-1:0] r_den6;
    logic signed [NUMW-1:0] r_nu;
    logic signed [NUMW-1:0] r_nv;
    logic [DENW-1:0]        r_den_mag;
    logic [NUMW-1:0]        r_mag [2];
    t_side                  r_side;
    logic [3:0]             r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 4: the six cross products
            r_m[0] <= i_dot[DOT_00] * i_dot[DOT_11];
            r_m[1] <= i_dot[DOT_01] * i_dot[DOT_01];
            r_m[2] <= i_dot[DOT_11] * i_dot[DOT_20];
            r_m[3] <= i_dot[DOT_01] * i_dot[DOT_21];
            r_m[4] <= i_dot[DOT_00] * i_dot[DOT_21];
            r_m[5] <= i_dot[DOT_01] * i_dot[DOT_20];
            // stage 5: denominator and weight numerators
            r_den5 <= DENW'(r_m[0]) - DENW'(r_m[1]);
            r_nx   <= DENW'(r_m[2]) - DENW'(r_m[3]);
            r_ny   <= DENW'(r_m[4]) - DENW'(r_m[5]);
            // stage 6: u takes y, v takes x + y
            r_den6 <= r_den5;
            r_nu   <= NUMW'(r_ny);
            r_nv   <= NUMW'(r_nx) + NUMW'(r_ny);
            // stage 7: magnitudes and quotient signs
            r_den_mag    <= r_den6[DENW-1] ? DENW'(-r_den6) : DENW'(r_den6);
            r_mag[0]     <= r_nu[NUMW-1] ? NUMW'(-r_nu) : NUMW'(r_nu);
            r_mag[1]     <= r_nv[NUMW-1] ? NUMW'(-r_nv) : NUMW'(r_nv);
            r_side.degen <= (r_den6 == '0);
            r_side.neg   <= {r_nv[NUMW-1] ^ r_den6[DENW-1],
                             r_nu[NUMW-1] ^ r_den6[DENW-1]};
        end
    end

    assign o_valid = r_v[3];
    assign o_den   = r_den_mag;
    assign o_mag   = r_mag;
    assign o_side  = r_side;

endmodule

`default_nettype wire

>>> rtl/tbuv_div.sv
// Two-lane restoring divider, one quotient bit per pipeline stage.
`default_nettype none

module tbuv_div import tbuv_pkg::*; #(
    parameter int CW  = 16,
    parameter int OFB = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [4*CW+8:0] i_den,
    input  wire logic [4*CW+9:0] i_mag [2],
    input  wire t_side          i_side,
    output logic                o_valid,
    output logic [QW-1:0]       o_q [2],
    output logic [1:0]          o_ovf,
    output t_side               o_side
);
    localparam int DENW = 4 * CW + 9;
    localparam int NUMW = DENW + 1;
    localparam int NW   = NUMW + OFB;
    localparam int HIW  = NW - QW;
    localparam int CMPW = (HIW > DENW) ? HIW : DENW;

    logic [NW-1:0]   w_n [2];
    logic [CMPW-1:0] w_hi [2];
    logic [CMPW-1:0] w_d;

    logic [DENW-1:0] r_rem [QW+1][2];
    logic [QW-1:0]   r_lo  [QW+1][2];
    logic [QW-1:0]   r_q   [QW+1][2];
    logic [1:0]      r_ovf [QW+1];
    logic [DENW-1:0] r_d   [QW+1];
    t_side           r_side [QW+1];
    logic [QW:0]     r_v;

    // scaled dividend and the part above the quotient bits
    always_comb begin
        w_d = CMPW'(i_den);
        for (int l = 0; l < 2; l++) begin
            w_n[l]  = {i_mag[l], {OFB{1'b0}}};
            w_hi[l] = CMPW'(w_n[l][NW-1:QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    // entry stage: overflow check, the high part seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_ovf[0][l] <= (w_hi[l] >= w_d);
                r_rem[0][l] <= w_hi[l][DENW-1:0];
                r_lo[0][l]  <= w_n[l][QW-1:0];
                r_q[0][l]   <= '0;
            end
            r_d[0]    <= i_den;
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s <= QW; s++) begin : g_stage
        logic [DENW:0] w_trial [2];
        logic [1:0]    w_ge;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_trial[l] = {r_rem[s-1][l], r_lo[s-1][l][QW-s]};
                w_ge[l]    = (w_trial[l] >= {1'b0, r_d[s-1]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= w_ge[l] ? DENW'(w_trial[l] - {1'b0, r_d[s-1]})
                                           : DENW'(w_trial[l]);
                    r_lo[s][l]  <= r_lo[s-1][l];
                    r_q[s][l]   <= {r_q[s-1][l][QW-2:0], w_ge[l]};
                end
                r_ovf[s]  <= r_ovf[s-1];
                r_d[s]    <= r_d[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_q     = r_q[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_side  = r_side[QW];

endmodule

`default_nettype wire

>>> rtl/triangle_barycentric_uv_unit.sv
// Top level of the barycentric texture coordinate unit.
//
// Usage: load the three triangle vertices through i_cfg (index 0, 1, 2 =
// vertices a, b, c; each word packs signed Q8.8 x, y, z from bit 0 up;
// index 3 is ignored). i_cfg is always ready. Then stream query points on
// i_point; each gives one item on o_uv: tex_u = weight y, tex_v = x + y,
// both signed Q3.14, truncated toward zero and saturated (clipped set),
// or all zero with degenerate set when the triangle has no area.
// The pipeline has three stages of edge vectors and dot products,
// four stages of cross products and magnitudes, twenty divider stages
// (an overflow check then one quotient bit each) and the output register.
// Throughput is one item per clock unless the output stalls; the whole
// pipeline advances together. When the receiver stalls a held result,
// the pipeline freezes and i_point.ready drops in the same cycle; nothing
// is lost or repeated. Reset (synchronous, active low) clears all valid
// bits and the vertex registers to zero.
`default_nettype none

module triangle_barycentric_uv_unit import tbuv_pkg::*; #(
    parameter int COORD_WIDTH   = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tbuv_point_if.sink i_point,
    tbuv_cfg_if.sink   i_cfg,
    tbuv_uv_if.source  o_uv
);
    localparam int CW   = COORD_WIDTH;
    localparam int DOTW = 2 * CW + 4;
    localparam int DENW = 4 * CW + 9;
    localparam int NUMW = DENW + 1;
    localparam logic [QW-1:0] Q_POS_MAX = QW'((1 << (OUT_W - 1)) - 1);
    localparam logic [QW-1:0] Q_NEG_MAX = QW'(1 << (OUT_W - 1));
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic [3*CW-1:0]        r_va;
    logic [3*CW-1:0]        r_vb;
    logic [3*CW-1:0]        r_vc;
    logic                   w_en;
    logic                   w_f_valid;
    logic signed [DOTW-1:0] w_dot [NUM_DOTS];
    logic                   w_c_valid;
    logic [DENW-1:0]        w_den;
    logic [NUMW-1:0]        w_mag [2];
    t_side                  w_c_side;
    logic                   w_d_valid;
    logic [QW-1:0]          w_q [2];
    logic [1:0]             w_ovf;
    t_side                  w_d_side;
    logic [OUT_W-1:0]       w_res [2];
    logic [1:0]             w_clip;

    logic                   r_out_valid;
    logic signed [OUT_W-1:0] r_tex_u;
    logic signed [OUT_W-1:0] r_tex_v;
    logic                   r_degen;
    logic                   r_clip;

    // vertex registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
            r_vc <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_VERTEX_A: r_va <= i_cfg.data;
                REG_VERTEX_B: r_vb <= i_cfg.data;
                REG_VERTEX_C: r_vc <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a held result is stalled
    assign w_en          = !r_out_valid || o_uv.ready;
    assign i_point.ready = w_en;

    tbuv_front #(.CW(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_point.valid),
        .i_px    (i_point.point_x),
        .i_py    (i_point.point_y),
        .i_pz    (i_point.point_z),
        .i_va    (r_va),
        .i_vb    (r_vb),
        .i_vc    (r_vc),
        .o_valid (w_f_valid),
        .o_dot   (w_dot)
    );

    tbuv_cramer #(.CW(CW)) u_cramer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_dot   (w_dot),
        .o_valid (w_c_valid),
        .o_den   (w_den),
        .o_mag   (w_mag),
        .o_side  (w_c_side)
    );

    tbuv_div #(.CW(CW), .OFB(OUT_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c_valid),
        .i_den   (w_den),
        .i_mag   (w_mag),
        .i_side  (w_c_side),
        .o_valid (w_d_valid),
        .o_q     (w_q),
        .o_ovf   (w_ovf),
        .o_side  (w_d_side)
    );

    // saturation and sign
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_clip[l] = 1'b0;
            if (w_d_side.neg[l]) begin
                if (w_ovf[l] || (w_q[l] > Q_NEG_MAX)) begin
                    w_res[l]  = OUT_MIN;
                    w_clip[l] = 1'b1;
                end else begin
                    w_res[l] = OUT_W'(0) - w_q[l][OUT_W-1:0];
                end
            end else begin
                if (w_ovf[l] || (w_q[l] > Q_POS_MAX)) begin
                    w_res[l]  = OUT_MAX;
                    w_clip[l] = 1'b1;
                end else begin
                    w_res[l] = w_q[l][OUT_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_degen <= w_d_side.degen;
            if (w_d_side.degen) begin
                r_tex_u <= '0;
                r_tex_v <= '0;
                r_clip  <= 1'b0;
            end else begin
                r_tex_u <= signed'(w_res[0]);
                r_tex_v <= signed'(w_res[1]);
                r_clip  <= |w_clip;
            end
        end
    end

    assign o_uv.valid      = r_out_valid;
    assign o_uv.tex_u      = r_tex_u;
    assign o_uv.tex_v      = r_tex_v;
    assign o_uv.degenerate = r_degen;
    assign o_uv.clipped    = r_clip;

`ifndef SYNTHESIS
    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_uv.valid)
        else $error("result valid right after reset");

    // a degenerate triangle gives zeros and no clipping
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_uv.valid && o_uv.degenerate) |->
            (o_uv.tex_u == '0 && o_uv.tex_v == '0 && !o_uv.clipped))
        else $error("degenerate result not cleared");

    // clipping leaves at least one output at a range limit
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_uv.valid && o_uv.clipped) |->
            (o_uv.tex_u == OUT_MAX || o_uv.tex_u == OUT_MIN ||
             o_uv.tex_v == OUT_MAX || o_uv.tex_v == OUT_MIN))
        else $error("clipped set without a saturated output");

    // a stalled result freezes the whole pipe
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_uv.valid && !o_uv.ready) |-> !i_point.ready)
        else $error("input taken while result stalled");
`endif

endmodule

`default_nettype wire
